// ----- sv/wtk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wtk_pkg;

	localparam int MAX_WORD  = 32;
	localparam int LINE_BITS = 24;

	localparam int AW = $clog2(MAX_WORD);
	localparam int LW = $clog2(MAX_WORD + 1);

	localparam int IN_DATA_W  = 8;
	localparam int IN_USER_W  = 2;
	localparam int OUT_BITS   = 8 + LINE_BITS + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		KIND_TEXT = 2'd0,
		KIND_EOL  = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		SC_SPACE = 3'b001,
		SC_WORD  = 3'b010,
		SC_NUM   = 3'b100
	} sc_state_t;

	// word emission request, control -> emitter
	typedef struct packed {
		logic                 valid;
		logic [LW-1:0]        n;
		logic                 trunc;
		logic [LINE_BITS-1:0] line;
		logic                 done;
	} emit_req_t;

	function automatic logic is_letter(logic [7:0] c);
		logic [7:0] l;
		begin
			l = c | 8'h20;
			return (l >= 8'h61) && (l <= 8'h7A);
		end
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

`default_nettype wire

// ----- sv/wtk_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wtk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/wtk_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wtk_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_acc,
	input  wire logic [1:0]                        in_kind,
	input  wire logic [7:0]                        in_ch,
	input  wire logic                              emit_busy,
	output logic                                   pend_busy,
	output wtk_pkg::emit_req_t                     req,
	output logic                                   we,
	output logic      [wtk_pkg::AW-1:0]            waddr,
	output logic      [7:0]                        wdata
);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_STORE,
		ACT_START,
		ACT_CLEAR,
		ACT_EMIT
	} act_t;

	typedef struct packed {
		wtk_pkg::sc_state_t st;
		act_t               act;
	} scan_out_t;

	localparam logic [wtk_pkg::LW-1:0] LEN_MAX = wtk_pkg::LW'(wtk_pkg::MAX_WORD);
	localparam logic [wtk_pkg::LW-1:0] LEN_CAP = wtk_pkg::LW'(wtk_pkg::MAX_WORD - 1);

	wtk_pkg::sc_state_t             st_q, st_n;
	logic [wtk_pkg::LW-1:0]         len_q, len_n;
	logic                           ovf_q, ovf_n;
	logic                           hyph_q, hyph_n;
	logic                           join_q, join_n;
	logic [wtk_pkg::LINE_BITS-1:0]  line_q, line_n;
	logic                           pend_q, pend_n;
	logic [7:0]                     pend_ch_q, pend_ch_n;

	function automatic scan_out_t scan_step(wtk_pkg::sc_state_t st, logic [7:0] c);
		scan_out_t r;
		logic      wl;
		begin
			wl = wtk_pkg::is_letter(c) || (c == wtk_pkg::CH_APOS);
			r.st = st;
			r.act = ACT_NONE;
			unique case (st)
				wtk_pkg::SC_WORD: begin
					priority if (wl) begin
						r.act = ACT_STORE;
					end else if (wtk_pkg::is_digit(c)) begin
						r.act = ACT_CLEAR;
						r.st = wtk_pkg::SC_NUM;
					end else begin
						r.act = ACT_EMIT;
						r.st = wtk_pkg::SC_SPACE;
					end
				end
				wtk_pkg::SC_NUM: begin
					if (!(wl || wtk_pkg::is_digit(c))) begin
						r.st = wtk_pkg::SC_SPACE;
					end
				end
				default: begin
					r.st = wtk_pkg::SC_SPACE;
					if (wtk_pkg::is_letter(c)) begin
						r.act = ACT_START;
						r.st = wtk_pkg::SC_WORD;
					end else if (wtk_pkg::is_digit(c)) begin
						r.st = wtk_pkg::SC_NUM;
					end
				end
			endcase
			return r;
		end
	endfunction

	always_comb begin
		logic       step_v [2];
		logic [7:0] step_c [2];
		scan_out_t  r;
		logic       emitted;

		st_n = st_q;
		len_n = len_q;
		ovf_n = ovf_q;
		hyph_n = hyph_q;
		join_n = join_q;
		line_n = line_q;
		pend_n = pend_q;
		pend_ch_n = pend_ch_q;
		req = '0;
		we = 1'b0;
		waddr = '0;
		wdata = in_ch;
		step_v[0] = 1'b0;
		step_v[1] = 1'b0;
		step_c[0] = wtk_pkg::CH_HYPHEN;
		step_c[1] = in_ch;
		emitted = 1'b0;
		r = '0;

		// deferred first letter of a word that followed a flushed hyphen
		if (pend_q && !emit_busy) begin
			we = 1'b1;
			waddr = '0;
			wdata = pend_ch_q;
			pend_n = 1'b0;
		end

		if (in_acc) begin
			unique case (wtk_pkg::kind_t'(in_kind))
				wtk_pkg::KIND_TEXT: begin
					step_v[0] = hyph_q;
					hyph_n = 1'b0;
					priority if (join_q) begin
						join_n = 1'b0;
						step_v[1] = 1'b1;
					end else if (in_ch == wtk_pkg::CH_HYPHEN) begin
						hyph_n = 1'b1;
					end else begin
						step_v[1] = 1'b1;
					end
				end
				wtk_pkg::KIND_EOL: begin
					if (hyph_q) begin
						hyph_n = 1'b0;
						join_n = 1'b1;
					end else begin
						join_n = 1'b0;
						step_v[0] = 1'b1;
						step_c[0] = wtk_pkg::CH_CR;
					end
					if (line_q != '1) begin
						line_n = line_q + wtk_pkg::LINE_BITS'(1);
					end
				end
				wtk_pkg::KIND_END: begin
					// a held hyphen only ends the word, so emit whatever word is open
					req.valid = 1'b1;
					req.done = 1'b1;
					req.line = line_q;
					if (st_q == wtk_pkg::SC_WORD) begin
						req.n = (len_q > LEN_CAP) ? LEN_CAP : len_q;
						req.trunc = ovf_q || (len_q > LEN_CAP);
					end
					st_n = wtk_pkg::SC_SPACE;
					len_n = '0;
					ovf_n = 1'b0;
					hyph_n = 1'b0;
					join_n = 1'b0;
					line_n = wtk_pkg::LINE_BITS'(1);
				end
				default: begin
				end
			endcase

			for (int i = 0; i < 2; i++) begin
				if (step_v[i]) begin
					r = scan_step(st_n, step_c[i]);
					st_n = r.st;
					unique case (r.act)
						ACT_STORE: begin
							if (len_n < LEN_MAX) begin
								we = 1'b1;
								waddr = len_n[wtk_pkg::AW-1:0];
								wdata = step_c[i];
								len_n = len_n + wtk_pkg::LW'(1);
							end else begin
								ovf_n = 1'b1;
							end
						end
						ACT_START: begin
							len_n = wtk_pkg::LW'(1);
							ovf_n = 1'b0;
							if (emitted) begin
								pend_n = 1'b1;
								pend_ch_n = step_c[i];
							end else begin
								we = 1'b1;
								waddr = '0;
								wdata = step_c[i];
							end
						end
						ACT_CLEAR: begin
							len_n = '0;
							ovf_n = 1'b0;
						end
						ACT_EMIT: begin
							emitted = 1'b1;
							req.valid = 1'b1;
							req.n = len_n;
							req.trunc = ovf_n;
							req.line = line_q;
							len_n = '0;
							ovf_n = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wtk_pkg::SC_SPACE;
			len_q <= '0;
			ovf_q <= 1'b0;
			hyph_q <= 1'b0;
			join_q <= 1'b0;
			line_q <= wtk_pkg::LINE_BITS'(1);
			pend_q <= 1'b0;
		end else begin
			st_q <= st_n;
			len_q <= len_n;
			ovf_q <= ovf_n;
			hyph_q <= hyph_n;
			join_q <= join_n;
			line_q <= line_n;
			pend_q <= pend_n;
		end
	end

	always_ff @(posedge clk) begin
		pend_ch_q <= pend_ch_n;
	end

	assign pend_busy = pend_q;

endmodule

`default_nettype wire

// ----- sv/wtk_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wtk_emit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire wtk_pkg::emit_req_t                   req,
	output logic                                      busy,
	output logic                                      re,
	output logic      [wtk_pkg::AW-1:0]               raddr,
	input  wire logic [7:0]                           rdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [wtk_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                      m_tlast,
	output logic                                      m_tuser
);

	typedef enum logic [2:0] {
		EM_IDLE = 3'b001,
		EM_READ = 3'b010,
		EM_DONE = 3'b100
	} em_state_t;

	em_state_t                      state_q;
	logic [wtk_pkg::LW-1:0]         n_q;
	logic [wtk_pkg::LW-1:0]         idx_q;
	logic                           trunc_q;
	logic [wtk_pkg::LINE_BITS-1:0]  line_q;
	logic                           done_q;

	logic                           valid_s1;
	logic                           last_s1;
	logic                           done_s1;
	logic                           trunc_s1;
	logic [wtk_pkg::LINE_BITS-1:0]  line_s1;

	logic                           out_valid_q;
	logic [7:0]                     out_letter_q;
	logic                           out_last_q;
	logic                           out_trunc_q;
	logic [wtk_pkg::LINE_BITS-1:0]  out_line_q;
	logic                           out_done_q;

	logic s1_adv, s1_free, is_last, load_done;

	assign s1_adv = valid_s1 && (!out_valid_q || m_tready);
	assign s1_free = !valid_s1 || s1_adv;
	assign is_last = (idx_q + wtk_pkg::LW'(1)) == n_q;
	assign re = (state_q == EM_READ) && s1_free;
	assign raddr = idx_q[wtk_pkg::AW-1:0];
	assign load_done = (state_q == EM_DONE) && s1_free;
	assign busy = (state_q != EM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				EM_IDLE: begin
					if (req.valid) begin
						state_q <= (req.n == '0) ? EM_DONE : EM_READ;
					end
				end
				EM_READ: begin
					if (re && is_last) begin
						state_q <= done_q ? EM_DONE : EM_IDLE;
					end
				end
				EM_DONE: begin
					if (s1_free) begin
						state_q <= EM_IDLE;
					end
				end
				default: state_q <= EM_IDLE;
			endcase
			if (re || load_done) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE) begin
			n_q <= req.n;
			trunc_q <= req.trunc;
			line_q <= req.line;
			done_q <= req.done;
			idx_q <= '0;
		end else if (re) begin
			idx_q <= idx_q + wtk_pkg::LW'(1);
		end
		if (re || load_done) begin
			last_s1 <= re && is_last;
			done_s1 <= load_done;
			trunc_s1 <= re && trunc_q;
			line_s1 <= line_q;
		end
		if (s1_adv) begin
			out_letter_q <= done_s1 ? 8'h00 : rdata;
			out_last_q <= last_s1;
			out_trunc_q <= trunc_s1;
			out_line_q <= line_s1;
			out_done_q <= done_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(wtk_pkg::OUT_DATA_W - wtk_pkg::OUT_BITS){1'b0}},
		out_trunc_q, out_line_q, out_letter_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_done_q;

endmodule

`default_nettype wire

// ----- sv/word_tokenizer_with_hyphen_join.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata                                    tuser        tlast
// s_*      in   [7:0] ch                                  [1:0] kind   -
// m_*      out  [7:0] letter, [31:8] line, [32] trunc    done_res     is_last
//
// Text bytes and line ends that emit nothing leave s_tready high.
// A finished word of n letters streams from the word buffer RAM at one letter per
// cycle while m_tready does not stall it (one read port, registered read); s_tready is
// low until the last read is issued. End of input adds a done result.
// A letter that opens a word right after a flushed hyphen is written in the cycle after
// the last emit read is issued. Reset clears scanner, line counter (to 1) and output valid.
// m_tready low stalls the output register and read stage; once the last read is
// issued, new items are taken even while results still wait.

module word_tokenizer_with_hyphen_join (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [wtk_pkg::IN_DATA_W-1:0]       s_tdata,   // [7:0] ch
	input  wire logic [wtk_pkg::IN_USER_W-1:0]       s_tuser,   // [1:0] kind
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [wtk_pkg::OUT_DATA_W-1:0]      m_tdata,   // [7:0] letter, [31:8] line_number,
	                                                            // [32] truncated, rest zero
	output logic                                     m_tlast,   // is_last
	output logic                                     m_tuser    // done_res
);

	wtk_pkg::emit_req_t       req;
	logic                     emit_busy;
	logic                     pend_busy;
	logic                     in_acc;
	logic                     we, re;
	logic [wtk_pkg::AW-1:0]   waddr, raddr;
	logic [7:0]               wdata, rdata;

	// items are taken while the emitter is idle and no deferred letter waits to be written
	assign s_tready = !emit_busy && !pend_busy;
	assign in_acc = s_tvalid && s_tready;

	wtk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.in_kind   (s_tuser),
		.in_ch     (s_tdata),
		.emit_busy (emit_busy),
		.pend_busy (pend_busy),
		.req       (req),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata)
	);

	// word buffer
	wtk_ram #(
		.WIDTH (8),
		.DEPTH (wtk_pkg::MAX_WORD)
	) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	wtk_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.busy     (emit_busy),
		.re       (re),
		.raddr    (raddr),
		.rdata    (rdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- sv/wtk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wtk_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic [wtk_pkg::IN_USER_W-1:0]       s_tuser,
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [wtk_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                                m_tlast,
	input  wire logic                                m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output transaction changed while stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00 && !m_tlast && !m_tdata[32])
		else $error("done transaction carries letter data");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:8] != '0)
		else $error("line number zero");

	a_end_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == wtk_pkg::KIND_END |=> !s_tready)
		else $error("input taken in the cycle after end of input");

endmodule

bind word_tokenizer_with_hyphen_join wtk_checker u_wtk_checker (.*);

`default_nettype wire
